// ===== rtl/core/rbb_pkg.sv =====
package rbb_pkg;

	localparam int COORD_BITS = 32;
	localparam int ANGLE_BITS = 16;
	localparam int TRIG_STEPS = 16;

	localparam int TAB_LEN = 24;
	localparam int NSTEPS = (TRIG_STEPS < TAB_LEN) ? TRIG_STEPS : TAB_LEN;

	localparam int WIDTH_BITS = COORD_BITS - 1;
	localparam int UNIT_BITS = 31;
	localparam int CW = 33;
	localparam int ZW = 33;
	localparam int PROD_BITS = UNIT_BITS + WIDTH_BITS;
	localparam int SUM_BITS = PROD_BITS + 1;
	localparam int EXT_BITS = SUM_BITS - 31;

	localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
	localparam logic signed [CW-1:0] Q30_ONE = CW'(64'sd1 << 30);

	localparam int CORDIC_LAT = NSTEPS + 2;
	localparam int LATENCY = CORDIC_LAT + 3;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [WIDTH_BITS-1:0] wx;
		logic [WIDTH_BITS-1:0] wy;
	} box_t;

	function automatic logic signed [ZW-1:0] atan_turn(int i);
		logic [29:0] v;
		case (i)
			0: v = 30'd536870912;
			1: v = 30'd316933406;
			2: v = 30'd167458907;
			3: v = 30'd85004756;
			4: v = 30'd42667331;
			5: v = 30'd21354465;
			6: v = 30'd10679838;
			7: v = 30'd5340245;
			8: v = 30'd2670163;
			9: v = 30'd1335087;
			10: v = 30'd667544;
			11: v = 30'd333772;
			12: v = 30'd166886;
			13: v = 30'd83443;
			14: v = 30'd41722;
			15: v = 30'd20861;
			16: v = 30'd10430;
			17: v = 30'd5215;
			18: v = 30'd2608;
			19: v = 30'd1304;
			20: v = 30'd652;
			21: v = 30'd326;
			22: v = 30'd163;
			23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return {{(ZW-30){1'b0}}, v};
	endfunction

endpackage

// ===== rtl/core/rotated_box_bounds_core.sv =====
// a request taken at a clock edge passes the cordic input register, one cordic
// stage per iteration, the cordic output register and the product, extent and
// bound registers; done then rises and the result is taken at the next edge
// throughput: one request per cycle, busy stays low, no result is ever held
// the result is on the ports for one cycle only, the receiver cannot stall
// reset: arst_n clears all valid bits at once, payload registers are not reset
module rotated_box_bounds_core
	import rbb_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [ANGLE_BITS-1:0]        angle,
	input  logic [WIDTH_BITS-1:0]        width_x,
	input  logic [WIDTH_BITS-1:0]        width_y,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] min_x,
	output logic signed [COORD_BITS-1:0] min_y,
	output logic signed [COORD_BITS-1:0] max_x,
	output logic signed [COORD_BITS-1:0] max_y
);

	localparam int SW = COORD_BITS + 2;
	localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'd1 << 30);

	box_t                 in_box;
	logic                 tr_valid;
	logic [UNIT_BITS-1:0] tr_cos;
	logic [UNIT_BITS-1:0] tr_sin;
	box_t                 tr_box;

	logic                         v_s1;
	logic [PROD_BITS-1:0]         cwx_s1, swy_s1, swx_s1, cwy_s1;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1;

	logic                         v_s2;
	logic [EXT_BITS-1:0]          mx_s2, my_s2;
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2;

	logic                         v_s3;
	logic signed [COORD_BITS-1:0] min_x_s3, min_y_s3, max_x_s3, max_y_s3;

	logic [SUM_BITS-1:0] sum_mx, sum_my;

	function automatic logic signed [COORD_BITS-1:0] sat(logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'({1'b0, {(COORD_BITS-1){1'b1}}});
		lo = -hi - SW'(1);
		if (v > hi)
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			return v[COORD_BITS-1:0];
	endfunction

	assign busy = 1'b0;

	assign in_box.cx = center_x;
	assign in_box.cy = center_y;
	assign in_box.wx = width_x;
	assign in_box.wy = width_y;

	rbb_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_angle  (angle),
		.in_box    (in_box),
		.out_valid (tr_valid),
		.out_cos   (tr_cos),
		.out_sin   (tr_sin),
		.out_box   (tr_box)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= tr_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// four partial extents
	always_ff @(posedge clk) begin
		cwx_s1 <= tr_cos * tr_box.wx;
		swy_s1 <= tr_sin * tr_box.wy;
		swx_s1 <= tr_sin * tr_box.wx;
		cwy_s1 <= tr_cos * tr_box.wy;
		cx_s1 <= tr_box.cx;
		cy_s1 <= tr_box.cy;
	end

	// round to nearest, halves up
	assign sum_mx = SUM_BITS'(cwx_s1) + SUM_BITS'(swy_s1) + ROUND_HALF;
	assign sum_my = SUM_BITS'(swx_s1) + SUM_BITS'(cwy_s1) + ROUND_HALF;

	always_ff @(posedge clk) begin
		mx_s2 <= sum_mx[SUM_BITS-1:31];
		my_s2 <= sum_my[SUM_BITS-1:31];
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
	end

	always_ff @(posedge clk) begin
		min_x_s3 <= sat(SW'(cx_s2) - $signed(SW'(mx_s2)));
		min_y_s3 <= sat(SW'(cy_s2) - $signed(SW'(my_s2)));
		max_x_s3 <= sat(SW'(cx_s2) + $signed(SW'(mx_s2)));
		max_y_s3 <= sat(SW'(cy_s2) + $signed(SW'(my_s2)));
	end

	assign done = v_s3;
	assign min_x = min_x_s3;
	assign min_y = min_y_s3;
	assign max_x = max_x_s3;
	assign max_y = max_y_s3;

endmodule

// ===== rtl/core/rbb_cordic.sv =====
module rbb_cordic
	import rbb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [ANGLE_BITS-1:0] in_angle,
	input  box_t                  in_box,
	output logic                  out_valid,
	output logic [UNIT_BITS-1:0]  out_cos,
	output logic [UNIT_BITS-1:0]  out_sin,
	output box_t                  out_box
);

	logic                 v_s   [NSTEPS+1];
	logic signed [CW-1:0] x_s   [NSTEPS+1];
	logic signed [CW-1:0] y_s   [NSTEPS+1];
	logic signed [ZW-1:0] z_s   [NSTEPS+1];
	logic                 odd_s [NSTEPS+1];
	box_t                 box_s [NSTEPS+1];

	logic                 vld_s;
	logic [UNIT_BITS-1:0] cos_abs_s;
	logic [UNIT_BITS-1:0] sin_abs_s;
	box_t                 box_end_s;

	logic [31:0]          turn;
	logic [UNIT_BITS-1:0] x_cl;
	logic [UNIT_BITS-1:0] y_cl;

	function automatic logic [UNIT_BITS-1:0] clamp_unit(logic signed [CW-1:0] v);
		if (v[CW-1])
			return '0;
		else if (v > Q30_ONE)
			return UNIT_BITS'(Q30_ONE);
		else
			return v[UNIT_BITS-1:0];
	endfunction

	assign turn = {in_angle, {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		x_s[0] <= GAIN_Q30;
		y_s[0] <= '0;
		z_s[0] <= {{(ZW-30){1'b0}}, turn[29:0]};
		odd_s[0] <= turn[30];
		box_s[0] <= in_box;
	end

	for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			odd_s[i+1] <= odd_s[i];
			box_s[i+1] <= box_s[i];
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_turn(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_turn(i);
			end
		end
	end

	assign x_cl = clamp_unit(x_s[NSTEPS]);
	assign y_cl = clamp_unit(y_s[NSTEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= 1'b0;
		else
			vld_s <= v_s[NSTEPS];
	end

	always_ff @(posedge clk) begin
		box_end_s <= box_s[NSTEPS];
		if (odd_s[NSTEPS]) begin
			cos_abs_s <= y_cl;
			sin_abs_s <= x_cl;
		end else begin
			cos_abs_s <= x_cl;
			sin_abs_s <= y_cl;
		end
	end

	assign out_valid = vld_s;
	assign out_cos = cos_abs_s;
	assign out_sin = sin_abs_s;
	assign out_box = box_end_s;

endmodule

// ===== rtl/core/rbb_checker.sv =====
module rbb_checker
	import rbb_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [COORD_BITS-1:0] center_x,
	input logic signed [COORD_BITS-1:0] center_y,
	input logic [WIDTH_BITS-1:0]        width_x,
	input logic [WIDTH_BITS-1:0]        width_y,
	input logic                         done,
	input logic signed [COORD_BITS-1:0] min_x,
	input logic signed [COORD_BITS-1:0] min_y,
	input logic signed [COORD_BITS-1:0] max_x,
	input logic signed [COORD_BITS-1:0] max_y
);

	logic req_zero;

	assign req_zero = start && !busy && width_x == '0 && width_y == '0;

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching request");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_x <= max_x) && (min_y <= max_y))
		else $error("lower bound above upper bound");

	a_zero_width_x: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(req_zero, LATENCY) |->
			min_x == $past(center_x, LATENCY) && max_x == $past(center_x, LATENCY))
		else $error("zero size box does not collapse to center x");

	a_zero_width_y: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(req_zero, LATENCY) |->
			min_y == $past(center_y, LATENCY) && max_y == $past(center_y, LATENCY))
		else $error("zero size box does not collapse to center y");

endmodule

bind rotated_box_bounds_core rbb_checker u_rbb_checker (.*);
